/* rtl/skva_pkg.sv */
// ----------------------------------------------------------------------------
// skva_pkg
// Shared types and constants for the sorted key/value accumulator.
// ----------------------------------------------------------------------------
package skva_pkg;

	localparam int Depth     = 1024;
	localparam int KeyBits   = 64;
	localparam int IdxW      = $clog2(Depth);
	localparam int CntW      = IdxW + 1;
	localparam logic [31:0] QOne = 32'h0001_0000;

	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_APPEND = 3'd1,
		CMD_SUM    = 3'd2,
		CMD_FIND   = 3'd3,
		CMD_READ   = 3'd4,
		CMD_WRITE  = 3'd5,
		CMD_ADDC   = 3'd6,
		CMD_LOWEST = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_IDX  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,       // issue read at addr
		S_RDW,      // read data lands
		S_EVAL,     // use read data
		S_SHIFT_RD, // shift: read entry i-1
		S_SHIFT_WR, // shift: write entry i
		S_SWEEP,    // add-constant / lowest sweep
		S_FINISH,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_TOP,
		PH_BOT,
		PH_MID,
		PH_WR
	} phase_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31])
			sat_add = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else
			sat_add = s[31:0];
	endfunction

endpackage

/* rtl/skva_ram.sv */
// ----------------------------------------------------------------------------
// skva_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module skva_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

/* rtl/sorted_key_value_accumulator_core.sv */
// ----------------------------------------------------------------------------
// sorted_key_value_accumulator_core
// Sorted key/value table with binary search, sorted insert and value sweeps.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_axis   in   tvalid/tready      tdata: cmd, key, value, position
// m_axis   out  tvalid/tready      tdata: status, found, slot, key_out, value_out, entries
// apb      in   psel/penable       set_mode at address 0
//
// One transaction at a time. Each RAM access goes through address,
// registered data and evaluate steps on one shared key/value port. A search
// is a binary search, an insert shifts each later entry up by one, and
// add-constant and lowest sweep every entry. Reset clears the state, the count
// and set_mode; stores are not cleared. s_axis_tready is low from accept
// until the result has been taken.
module sorted_key_value_accumulator_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cmd[2:0], key[66:3], value[98:67], position[108:99], zero pad
	input  logic [111:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[1:0], found[2], slot[13:3], key_out[77:14], value_out[109:78],
	// entries[120:110], zero pad
	output logic [127:0] m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [0:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import skva_pkg::*;

	state_t st_q, st_d;
	phase_t ph_q, ph_d;

	logic          set_mode_q;
	cmd_t          cmd_q;
	logic [KeyBits-1:0] key_q;
	logic [31:0]   val_q;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic [CntW-1:0] top_q, top_d, bot_q, bot_d, i_q, i_d;
	logic [1:0]    status_q, status_d;
	logic          found_q, found_d;
	logic [CntW-1:0] slot_q, slot_d;
	logic [KeyBits-1:0] kout_q, kout_d;
	logic [31:0]   vout_q, vout_d;
	logic [KeyBits-1:0] shk_q, shk_d;
	logic [31:0]   shv_q, shv_d;

	logic          we;
	logic [IdxW-1:0] addr;
	logic [KeyBits-1:0] wkey, rkey;
	logic [31:0]   wval, rval;

	cmd_t          in_cmd;
	logic [IdxW-1:0] in_pos;

	skva_ram #(.Width(KeyBits), .Depth(Depth)) u_key_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wkey), .rdata(rkey));
	skva_ram #(.Width(32), .Depth(Depth)) u_val_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wval), .rdata(rval));

	assign pready = 1'b1;
	assign prdata = {31'd0, set_mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			set_mode_q <= 1'b0;
		else if (psel && penable && pwrite && paddr == 1'b0)
			set_mode_q <= pwdata[0];
	end

	assign s_axis_tready = (st_q == S_IDLE);
	assign m_axis_tvalid = (st_q == S_OUT);
	assign m_axis_tdata  = {7'd0, cnt_q, vout_q, kout_q, slot_q, found_q, status_q};

	assign in_cmd = cmd_t'(s_axis_tdata[2:0]);
	assign in_pos = s_axis_tdata[108:99];

	logic [IdxW-1:0] addr_q, addr_d;
	logic [31:0] fsum;
	logic [31:0] forced;

	function automatic logic [31:0] fset(input logic m, input logic [31:0] v);
		fset = (m && v != 32'd0) ? QOne : v;
	endfunction

	assign fsum = sat_add(rval, val_q);
	assign addr = addr_q;

	always_comb begin
		st_d = st_q; ph_d = ph_q; cnt_d = cnt_q;
		top_d = top_q; bot_d = bot_q; i_d = i_q; addr_d = addr_q;
		status_d = status_q; found_d = found_q; slot_d = slot_q;
		kout_d = kout_q; vout_d = vout_q; shk_d = shk_q; shv_d = shv_q;
		we = 1'b0; wkey = rkey; wval = rval;
		forced = fset(set_mode_q, val_q);
		case (st_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					ph_d = PH_TOP; st_d = S_OUT;
					status_d = ST_OK; found_d = 1'b0; slot_d = '0;
					kout_d = '0; vout_d = '0;
					top_d = '0; bot_d = cnt_q - 1'b1; i_d = '0;
					addr_d = in_pos;
					case (in_cmd)
						CMD_CLEAR: cnt_d = '0;
						CMD_APPEND: begin
							if (cnt_q < CntW'(Depth)) begin
								addr_d = cnt_q[IdxW-1:0];
								st_d = S_FINISH;
							end else
								status_d = ST_FULL;
						end
						CMD_SUM, CMD_FIND: begin
							addr_d = '0;
							if (cnt_q != '0) st_d = S_RD;
							else if (in_cmd == CMD_SUM) st_d = S_FINISH;
						end
						CMD_READ, CMD_WRITE: begin
							if ({1'b0, in_pos} < cnt_q) st_d = S_RDW;
							else status_d = ST_IDX;
						end
						default: st_d = S_SWEEP;
					endcase
				end
			end
			S_RD: st_d = S_RDW;
			S_RDW: st_d = S_EVAL;
			S_EVAL: begin
				// binary search step on rkey
				if (rkey == key_q) begin
					found_d = 1'b1;
					slot_d = {1'b0, addr_q};
					st_d = S_FINISH;
				end else begin
					case (ph_q)
						PH_TOP: begin
							if (rkey > key_q) begin
								slot_d = '0; st_d = S_FINISH;
							end else begin
								ph_d = PH_BOT; addr_d = bot_q[IdxW-1:0]; st_d = S_RD;
							end
						end
						PH_BOT: begin
							if (rkey < key_q) begin
								slot_d = cnt_q; st_d = S_FINISH;
							end else if (bot_q - top_q <= CntW'(1)) begin
								slot_d = bot_q; st_d = S_FINISH;
							end else begin
								ph_d = PH_MID;
								addr_d = bot_q[CntW-1:1];
								st_d = S_RD;
							end
						end
						default: begin
							if (rkey > key_q) begin
								bot_d = {1'b0, addr_q};
							end else begin
								top_d = {1'b0, addr_q};
							end
							if (bot_d - top_d <= CntW'(1)) begin
								slot_d = bot_d; st_d = S_FINISH;
							end else begin
								addr_d = IdxW'(({1'b0, bot_d} + {1'b0, top_d}) >> 1);
								st_d = S_RD;
							end
						end
					endcase
				end
			end
			S_FINISH: begin
				// append write, or sum follow-up after search
				st_d = S_OUT;
				if (cmd_q == CMD_APPEND) begin
					we = 1'b1; wkey = key_q; wval = forced;
					cnt_d = cnt_q + 1'b1;
				end else if (cmd_q == CMD_SUM) begin
					if (found_q) begin
						addr_d = slot_q[IdxW-1:0];
						i_d = '0;
						st_d = S_SHIFT_RD; // reuse: read then write summed
						ph_d = PH_TOP;
					end else if (cnt_q >= CntW'(Depth)) begin
						status_d = ST_FULL;
					end else begin
						addr_d = slot_q[IdxW-1:0];
						i_d = cnt_q;
						ph_d = PH_BOT;
						st_d = S_SHIFT_RD;
					end
				end
			end
			S_SHIFT_RD: begin
				if (ph_q == PH_TOP) begin
					// matched: wait read of slot
					if (i_q == CntW'(2)) begin
						we = 1'b1; wkey = rkey; wval = fset(set_mode_q, fsum);
						st_d = S_OUT;
					end
					i_d = i_q + 1'b1;
				end else if (i_q == slot_q) begin
					// addr_q already points at the slot
					we = 1'b1;
					wkey = key_q; wval = forced;
					cnt_d = cnt_q + 1'b1;
					st_d = S_OUT;
				end else begin
					addr_d = IdxW'(i_q - 1'b1);
					st_d = S_SHIFT_WR;
					ph_d = PH_MID;
				end
			end
			S_SHIFT_WR: begin
				// MID: read i-1 issued, BOT: data back, WR: write to i
				case (ph_q)
					PH_MID: ph_d = PH_BOT;
					PH_BOT: begin
						shk_d = rkey; shv_d = rval;
						addr_d = IdxW'(i_q);
						ph_d = PH_WR;
					end
					default: begin
						we = 1'b1;
						wkey = shk_q; wval = shv_q;
						i_d = i_q - 1'b1;
						addr_d = IdxW'(i_q - 1'b1);
						ph_d = PH_BOT;
						st_d = S_SHIFT_RD;
					end
				endcase
			end
			S_SWEEP: begin
				// i counts entries, ph: TOP=issue, BOT=wait, MID=use
				case (ph_q)
					PH_TOP: begin
						if (i_q >= cnt_q) st_d = S_OUT;
						else begin addr_d = IdxW'(i_q); ph_d = PH_BOT; end
					end
					PH_BOT: ph_d = PH_MID;
					default: begin
						if (cmd_q == CMD_ADDC) begin
							we = 1'b1; wkey = rkey; wval = fsum;
						end else if (i_q == '0 || $signed(rval) < $signed(vout_q)) begin
							vout_d = rval;
						end
						i_d = i_q + 1'b1;
						ph_d = PH_TOP;
					end
				endcase
			end
			S_OUT: if (m_axis_tready) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase

		// read/write by index: S_RDW first sets PH_MID, then uses the read data
		if (st_q == S_RDW && (cmd_q == CMD_READ)) begin
			st_d = S_RDW;
			if (ph_q == PH_MID) begin
				kout_d = rkey; vout_d = rval; st_d = S_OUT;
			end else ph_d = PH_MID;
		end
		if (st_q == S_RDW && cmd_q == CMD_WRITE) begin
			st_d = S_RDW;
			if (ph_q == PH_MID) begin
				we = 1'b1; wkey = rkey; wval = val_q; st_d = S_OUT;
			end else ph_d = PH_MID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; ph_q <= PH_TOP; cnt_q <= '0;
		end else begin
			st_q <= st_d; ph_q <= ph_d; cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && s_axis_tvalid) begin
			cmd_q <= in_cmd;
			key_q <= s_axis_tdata[66:3];
			val_q <= s_axis_tdata[98:67];
		end
		top_q <= top_d; bot_q <= bot_d; i_q <= i_d; addr_q <= addr_d;
		status_q <= status_d; found_q <= found_d; slot_q <= slot_d;
		kout_q <= kout_d; vout_q <= vout_d; shk_q <= shk_d; shv_q <= shv_d;
	end
endmodule

/* rtl/skva_checker.sv */
// ----------------------------------------------------------------------------
// skva_checker
// Port-level checks for the sorted key/value accumulator.
// ----------------------------------------------------------------------------
module skva_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata
);
	a_no_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3) else $error("bad status");
endmodule

bind sorted_key_value_accumulator_core skva_checker u_skva_checker (.*);
